@@ rtl/core/otb_pkg.sv @@
// Shared types and constants for the one-shot/periodic timer bank.
`default_nettype none
package otb_pkg;

  localparam int SLOTS_DEFAULT = 16;
  localparam int T_W           = 48;
  localparam int PER_W         = 32;
  localparam int SLOT_W        = 4;
  localparam int RAM_W         = 1 + PER_W + T_W;

  localparam logic [T_W-1:0] T48_MAX = {T_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_ADDED = 2'd0,
    KIND_FULL  = 2'd1,
    KIND_FIRED = 2'd2
  } kind_t;

  typedef enum logic {
    ALU_ADD,
    ALU_LT
  } alu_op_t;

  typedef struct packed {
    alu_op_t        op;
    logic [T_W-1:0] a;
    logic [T_W-1:0] b;
  } alu_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_FIND,
    ST_ADD_SUM,
    ST_ADD_MIN,
    ST_TICK_CHK,
    ST_SCAN,
    ST_LOAD,
    ST_RELOAD,
    ST_MIN,
    ST_NEXT,
    ST_FLUSH
  } state_t;

endpackage
`default_nettype wire

@@ rtl/core/otb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module otb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/otb_alu.sv @@
// Shared 48-bit adder: saturating add or less-than compare.
`default_nettype none
module otb_alu import otb_pkg::*; (
  input  wire alu_req_t        req,
  output logic     [T_W-1:0] res,
  output logic                 lt
);

  logic           sub;
  logic [T_W-1:0] b_op;
  logic [T_W:0]   sum;

  always_comb begin
    sub  = (req.op == ALU_LT);
    b_op = sub ? ~req.b : req.b;
    sum  = {1'b0, req.a} + {1'b0, b_op} + {{T_W{1'b0}}, sub};
    // a - b carries out exactly when a >= b
    lt   = sub & ~sum[T_W];
    res  = (!sub && sum[T_W]) ? T48_MAX : sum[T_W-1:0];
  end

endmodule
`default_nettype wire

@@ rtl/core/oneshot_periodic_timer_bank_unit.sv @@
// Timer bank top level: sequencer, slot state, shared adder and slot RAM.
// A bank of NUM_SLOTS millisecond timers. An add request arms the lowest free
// slot with deadline now_ms + period_ms (saturating at 2^48-1) and returns one
// result (added, or full when no slot is free). A tick request fires every armed
// slot whose deadline is at or before now_ms, in ascending slot order; one-shot
// slots are freed, periodic slots re-arm at now_ms + period. Ticks that arrive
// before the earliest deadline, or to an empty bank, return nothing. All work
// goes through one shared 48-bit adder/comparator and one slot RAM read port,
// one request at a time. An add scans upward for the lowest free slot, writes
// its deadline and updates the earliest deadline; a full bank returns full. A
// tick checks the earliest deadline, then reads each armed slot, frees or re-arms
// fired ones and keeps the next deadline; both can stall on the result side.
`default_nettype none
module oneshot_periodic_timer_bank_unit import otb_pkg::*; #(
  parameter int NUM_SLOTS = SLOTS_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire logic              action,
  input  wire logic [T_W-1:0]    now_ms,
  input  wire logic              one_shot,
  input  wire logic [PER_W-1:0]  period_ms,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output logic      [1:0]        kind,
  output logic      [SLOT_W-1:0] slot,
  output logic                   last
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam logic [SW-1:0] LAST_IDX = SW'(NUM_SLOTS - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(NUM_SLOTS);

  state_t state, state_next;

  // latched request
  logic [T_W-1:0]    now_r;
  logic              oneshot_r;
  logic [PER_W-1:0]  period_r;

  logic [SW-1:0]        idx;
  logic [CW-1:0]        cnt;
  logic [NUM_SLOTS-1:0] slot_valid;
  logic [T_W-1:0]       earliest;
  logic [T_W-1:0]       next_min;
  logic [T_W-1:0]       cand;
  logic                 held_valid;
  logic [SW-1:0]        held_idx;

  kind_t             kind_r;
  logic [SLOT_W-1:0] slot_r;
  logic              last_r;

  // datapath
  alu_req_t       alu_req;
  logic [T_W-1:0] alu_res;
  logic           alu_lt;

  logic             ram_we, ram_re;
  logic [RAM_W-1:0] ram_wdata, ram_rdata;
  logic [T_W-1:0]   rd_dl;
  logic [PER_W-1:0] rd_period;
  logic             rd_oneshot;

  // control
  logic              accept, stall, full, fire, skip;
  logic              push, push_last;
  kind_t             push_kind;
  logic [SLOT_W-1:0] push_slot;
  logic              set_valid, clr_valid, cnt_inc, cnt_dec, idx_inc;
  logic              earliest_ld, min_ld, min_init, cand_ld, held_ld, held_clr;
  logic [T_W-1:0]    earliest_val, cand_val;

  function automatic state_t act_r_sel(input logic a);
    return a ? ST_TICK_CHK : ST_ADD_FIND;
  endfunction

  assign req_ready  = (state == ST_IDLE);
  assign accept     = req_valid & req_ready;
  assign stall      = rsp_valid & ~rsp_ready;
  assign full       = (cnt == FULL_CNT);
  assign rd_dl      = ram_rdata[T_W-1:0];
  assign rd_period  = ram_rdata[T_W +: PER_W];
  assign rd_oneshot = ram_rdata[RAM_W-1];
  assign fire       = ~alu_lt;
  assign skip       = (cnt == '0) | alu_lt;

  otb_alu u_alu (
    .req (alu_req),
    .res (alu_res),
    .lt  (alu_lt)
  );

  otb_ram #(
    .WIDTH (RAM_W),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = act_r_sel(action);
        end
      end
      ST_ADD_FIND: begin
        if (full) begin
          if (!stall) state_next = ST_IDLE;
        end else if (!slot_valid[idx]) begin
          state_next = ST_ADD_SUM;
        end
      end
      ST_ADD_SUM:  state_next = ST_ADD_MIN;
      ST_ADD_MIN:  if (!stall) state_next = ST_IDLE;
      ST_TICK_CHK: state_next = skip ? ST_IDLE : ST_SCAN;
      ST_SCAN:     state_next = slot_valid[idx] ? ST_LOAD : ST_NEXT;
      ST_LOAD: begin
        if (!fire) begin
          state_next = ST_MIN;
        end else if (!(held_valid && stall)) begin
          state_next = rd_oneshot ? ST_NEXT : ST_RELOAD;
        end
      end
      ST_RELOAD:   state_next = ST_MIN;
      ST_MIN:      state_next = ST_NEXT;
      ST_NEXT:     state_next = (idx == LAST_IDX) ? ST_FLUSH : ST_SCAN;
      ST_FLUSH:    if (!(held_valid && stall)) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    alu_req      = '{op: ALU_ADD, a: now_r, b: {{(T_W-PER_W){1'b0}}, period_r}};
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_wdata    = {oneshot_r, period_r, alu_res};
    push         = 1'b0;
    push_kind    = KIND_FIRED;
    push_slot    = SLOT_W'(held_idx);
    push_last    = 1'b0;
    set_valid    = 1'b0;
    clr_valid    = 1'b0;
    cnt_inc      = 1'b0;
    cnt_dec      = 1'b0;
    idx_inc      = 1'b0;
    earliest_ld  = 1'b0;
    earliest_val = next_min;
    min_ld       = 1'b0;
    min_init     = 1'b0;
    cand_ld      = 1'b0;
    cand_val     = alu_res;
    held_ld      = 1'b0;
    held_clr     = 1'b0;
    case (state)
      ST_ADD_FIND: begin
        if (full) begin
          if (!stall) begin
            push      = 1'b1;
            push_kind = KIND_FULL;
            push_slot = '0;
            push_last = 1'b1;
          end
        end else if (slot_valid[idx]) begin
          idx_inc = 1'b1;
        end
      end
      ST_ADD_SUM: begin
        ram_we  = 1'b1;
        cand_ld = 1'b1;
      end
      ST_ADD_MIN: begin
        alu_req = '{op: ALU_LT, a: cand, b: earliest};
        if (!stall) begin
          push         = 1'b1;
          push_kind    = KIND_ADDED;
          push_slot    = SLOT_W'(idx);
          push_last    = 1'b1;
          set_valid    = 1'b1;
          cnt_inc      = 1'b1;
          earliest_val = cand;
          earliest_ld  = (cnt == '0) | alu_lt;
        end
      end
      ST_TICK_CHK: begin
        alu_req = '{op: ALU_LT, a: now_r, b: earliest};
        if (!skip) begin
          min_init = 1'b1;
          held_clr = 1'b1;
        end
      end
      ST_SCAN: begin
        ram_re = slot_valid[idx];
      end
      ST_LOAD: begin
        alu_req = '{op: ALU_LT, a: now_r, b: rd_dl};
        if (!fire) begin
          cand_ld  = 1'b1;
          cand_val = rd_dl;
        end else if (!(held_valid && stall)) begin
          push      = held_valid;
          held_ld   = 1'b1;
          clr_valid = rd_oneshot;
          cnt_dec   = rd_oneshot;
        end
      end
      ST_RELOAD: begin
        alu_req   = '{op: ALU_ADD, a: now_r, b: {{(T_W-PER_W){1'b0}}, rd_period}};
        ram_we    = 1'b1;
        ram_wdata = {rd_oneshot, rd_period, alu_res};
        cand_ld   = 1'b1;
      end
      ST_MIN: begin
        alu_req = '{op: ALU_LT, a: cand, b: next_min};
        min_ld  = alu_lt;
      end
      ST_NEXT: begin
        idx_inc = (idx != LAST_IDX);
      end
      ST_FLUSH: begin
        earliest_ld = 1'b1;
        if (held_valid && !stall) begin
          push      = 1'b1;
          push_last = 1'b1;
          held_clr  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      slot_valid <= '0;
      earliest   <= '0;
      held_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= push | (rsp_valid & ~rsp_ready);
      if (set_valid) slot_valid[idx] <= 1'b1;
      if (clr_valid) slot_valid[idx] <= 1'b0;
      if (cnt_inc) begin
        cnt <= cnt + 1'b1;
      end else if (cnt_dec) begin
        cnt <= cnt - 1'b1;
      end
      if (earliest_ld) earliest <= earliest_val;
      if (held_ld) begin
        held_valid <= 1'b1;
      end else if (held_clr) begin
        held_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now_r     <= now_ms;
      oneshot_r <= one_shot;
      period_r  <= period_ms;
      idx       <= '0;
    end else if (idx_inc) begin
      idx <= idx + 1'b1;
    end
    if (min_init) begin
      next_min <= T48_MAX;
    end else if (min_ld) begin
      next_min <= cand;
    end
    if (cand_ld) cand <= cand_val;
    if (held_ld) held_idx <= idx;
    if (push) begin
      kind_r <= push_kind;
      slot_r <= push_slot;
      last_r <= push_last;
    end
  end

  assign kind = kind_r;
  assign slot = slot_r;
  assign last = last_r;

`ifndef SYNTH
  a_cnt_matches_valid: assert property (@(posedge clk) disable iff (rst)
    cnt == $countones(slot_valid))
    else $error("slot count does not match valid bits");

  a_idle_no_held: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !held_valid)
    else $error("fired result left pending at idle");

  a_add_increments: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADD_MIN && !stall) |=> (cnt == $past(cnt) + 1'b1))
    else $error("add did not claim a slot");
`endif

endmodule
`default_nettype wire
